/* design/nat_pkg.sv */
// Shared types, sizes and codes for the NAT translation table.
// Depends on nothing; every other design file but nat_ram refers to it by scoped names.
`timescale 1ns / 1ps
package nat_pkg;

  localparam int unsigned Buckets = 1024;
  localparam int unsigned Entries = 256;
  localparam int unsigned BktW    = $clog2(Buckets);
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned PtrW    = IdxW + 1;

  localparam logic [PtrW-1:0] PtrNull = PtrW'(Entries);

  localparam logic [31:0] FnvBasis = 32'h811C_9DC5;
  localparam logic [31:0] FnvPrime = 32'h0100_0193;

  // command codes
  localparam logic [1:0] CmdInsert    = 2'd0;
  localparam logic [1:0] CmdFwdLookup = 2'd1;
  localparam logic [1:0] CmdRevLookup = 2'd2;
  localparam logic [1:0] CmdRemove    = 2'd3;

  // status codes
  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
    logic [31:0] gw_ip;
    logic [15:0] gw_port;
  } entry_t;

  typedef struct packed {
    logic [1:0]      command;
    entry_t          key;
    logic [BktW-1:0] key_bkt;
    logic [BktW-1:0] gw_bkt;
  } job_t;

endpackage

/* design/nat_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module nat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/nat_hash.sv */
// Iterative word-wise FNV-1a over five words, one multiply per cycle.
// Depends on nat_pkg.
`timescale 1ns / 1ps
module nat_hash (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [4:0][31:0]           words_i,
  output logic                       done_o,
  output logic [nat_pkg::BktW-1:0]   bkt_o
);

  logic [31:0]      h_q;
  logic [4:0][31:0] words_q;
  logic [2:0]       cnt_q;
  logic             run_q;
  logic             done_q;
  logic [31:0]      mix;
  logic [31:0]      prod;

  assign mix  = h_q ^ words_q[cnt_q];
  assign prod = 32'(mix * nat_pkg::FnvPrime);

  // control: run five rounds, then pulse done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: load basis, fold one word per round
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q     <= nat_pkg::FnvBasis;
      words_q <= words_i;
    end else if (run_q) begin
      h_q <= prod;
    end
  end

  assign done_o = done_q;
  assign bkt_o  = h_q[nat_pkg::BktW-1:0];

endmodule

/* design/nat_front.sv */
// Front end: takes one item, hashes its forward and reverse keys, queues the job.
// Depends on nat_pkg and nat_hash.
`timescale 1ns / 1ps
module nat_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [1:0]     command_i,
  input  nat_pkg::entry_t item_i,
  output logic           full_o,
  output nat_pkg::job_t  job_o,
  output logic           job_valid_o,
  input  logic           job_pop_i
);

  nat_pkg::job_t stage_q;
  logic          busy_q;
  logic          ready_q;
  logic          key_done;
  logic          gw_done;
  logic [nat_pkg::BktW-1:0] key_bkt;
  logic [nat_pkg::BktW-1:0] gw_bkt;
  logic [4:0][31:0] key_words;
  logic [4:0][31:0] gw_words;

  nat_pkg::job_t q_q [2];
  logic          wp_q;
  logic          rp_q;
  logic [1:0]    cnt_q;
  logic          enq;
  logic          deq;

  // hash words in model order: first word at index 0
  assign key_words = {32'(item_i.protocol), 32'(item_i.dport), 32'(item_i.sport),
                      item_i.dst_ip, item_i.src_ip};
  assign gw_words  = {32'(item_i.protocol), 32'(item_i.gw_port), 32'(item_i.dport),
                      item_i.gw_ip, item_i.dst_ip};

  nat_hash u_key_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept_i),
    .words_i (key_words),
    .done_o  (key_done),
    .bkt_o   (key_bkt)
  );

  nat_hash u_gw_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept_i),
    .words_i (gw_words),
    .done_o  (gw_done),
    .bkt_o   (gw_bkt)
  );

  assign enq = ready_q && (cnt_q != 2'd2);
  assign deq = job_pop_i && (cnt_q != 2'd0);

  // staging control: busy from accept until the job is queued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      ready_q <= 1'b0;
    end else begin
      if (accept_i) begin
        busy_q <= 1'b1;
      end else if (enq) begin
        busy_q  <= 1'b0;
        ready_q <= 1'b0;
      end else if (key_done && gw_done) begin
        ready_q <= 1'b1;
      end
    end
  end

  // staging payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stage_q.command <= command_i;
      stage_q.key     <= item_i;
    end
    if (key_done && gw_done) begin
      stage_q.key_bkt <= key_bkt;
      stage_q.gw_bkt  <= gw_bkt;
    end
  end

  // two-deep job queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (enq) wp_q <= ~wp_q;
      if (deq) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_q[wp_q] <= stage_q;
    end
  end

  assign full_o      = busy_q;
  assign job_o       = q_q[rp_q];
  assign job_valid_o = (cnt_q != 2'd0);

endmodule

/* design/nat_back.sv */
// Back end: owns bucket heads, entry pool and free stack; runs each job to a result.
// Depends on nat_pkg, nat_ram and nat_hash.
`timescale 1ns / 1ps
module nat_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nat_pkg::job_t   job_i,
  input  logic            job_valid_i,
  output logic            job_pop_o,
  output logic            init_o,
  output logic            out_valid_o,
  input  logic            out_pop_i,
  output logic [1:0]      status_o,
  output nat_pkg::entry_t res_o
);

  localparam int unsigned BktW = nat_pkg::BktW;
  localparam int unsigned IdxW = nat_pkg::IdxW;
  localparam int unsigned PtrW = nat_pkg::PtrW;
  localparam int unsigned EntW = $bits(nat_pkg::entry_t);

  localparam logic [3:0] SClear  = 4'd0;
  localparam logic [3:0] SIdle   = 4'd1;
  localparam logic [3:0] SInsRd  = 4'd2;
  localparam logic [3:0] SInsWr  = 4'd3;
  localparam logic [3:0] SHead   = 4'd4;
  localparam logic [3:0] SHeadW  = 4'd5;
  localparam logic [3:0] SChk    = 4'd6;
  localparam logic [3:0] SCmp    = 4'd7;
  localparam logic [3:0] SRHash  = 4'd8;
  localparam logic [3:0] SRHead  = 4'd9;
  localparam logic [3:0] SRHeadW = 4'd10;
  localparam logic [3:0] SRChk   = 4'd11;
  localparam logic [3:0] SRCmp   = 4'd12;
  localparam logic [3:0] SFree   = 4'd13;

  logic [3:0]      state_q, state_d;
  nat_pkg::job_t   job_q;
  logic [PtrW-1:0] cur_q, cur_d;
  logic [PtrW-1:0] prev_q, prev_d;
  logic [PtrW-1:0] r_q, r_d;
  logic [BktW-1:0] rbkt_q;
  logic [BktW-1:0] clr_q;
  logic [IdxW:0]   fc_q, fc_d;
  nat_pkg::entry_t ent_q;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      status_q, status_d;
  nat_pkg::entry_t res_q, res_d;
  logic            take;

  // memory ports
  logic            fh_we, rh_we, en_we, nf_we, nr_we, fs_we;
  logic [BktW-1:0] fh_waddr, fh_raddr, rh_waddr, rh_raddr;
  logic [PtrW-1:0] fh_wdata, fh_rdata, rh_wdata, rh_rdata;
  logic [IdxW-1:0] en_waddr, en_raddr, nf_waddr, nf_raddr, nr_waddr, nr_raddr;
  logic [IdxW-1:0] fs_waddr, fs_raddr, fs_wdata, fs_rdata;
  nat_pkg::entry_t en_wdata, en_rdata;
  logic [PtrW-1:0] nf_wdata, nf_rdata, nr_wdata, nr_rdata;

  // remove-side hash of the reverse tuple
  logic             rh_start;
  logic             rh_done;
  logic [BktW-1:0]  rh_bkt;
  logic [4:0][31:0] rh_words;

  logic is_rev;
  logic hit;
  logic [PtrW-1:0] nxt;

  nat_ram #(.Width(PtrW), .Depth(nat_pkg::Buckets)) u_fwd_head (
    .clk_i(clk_i), .we_i(fh_we), .waddr_i(fh_waddr), .wdata_i(fh_wdata),
    .raddr_i(fh_raddr), .rdata_o(fh_rdata));
  nat_ram #(.Width(PtrW), .Depth(nat_pkg::Buckets)) u_rev_head (
    .clk_i(clk_i), .we_i(rh_we), .waddr_i(rh_waddr), .wdata_i(rh_wdata),
    .raddr_i(rh_raddr), .rdata_o(rh_rdata));
  nat_ram #(.Width(EntW), .Depth(nat_pkg::Entries)) u_entry (
    .clk_i(clk_i), .we_i(en_we), .waddr_i(en_waddr), .wdata_i(en_wdata),
    .raddr_i(en_raddr), .rdata_o(en_rdata));
  nat_ram #(.Width(PtrW), .Depth(nat_pkg::Entries)) u_next_fwd (
    .clk_i(clk_i), .we_i(nf_we), .waddr_i(nf_waddr), .wdata_i(nf_wdata),
    .raddr_i(nf_raddr), .rdata_o(nf_rdata));
  nat_ram #(.Width(PtrW), .Depth(nat_pkg::Entries)) u_next_rev (
    .clk_i(clk_i), .we_i(nr_we), .waddr_i(nr_waddr), .wdata_i(nr_wdata),
    .raddr_i(nr_raddr), .rdata_o(nr_rdata));
  nat_ram #(.Width(IdxW), .Depth(nat_pkg::Entries)) u_free_stack (
    .clk_i(clk_i), .we_i(fs_we), .waddr_i(fs_waddr), .wdata_i(fs_wdata),
    .raddr_i(fs_raddr), .rdata_o(fs_rdata));

  assign rh_words = {32'(en_rdata.protocol), 32'(en_rdata.gw_port), 32'(en_rdata.dport),
                     en_rdata.gw_ip, en_rdata.dst_ip};

  nat_hash u_rev_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rh_start),
    .words_i (rh_words),
    .done_o  (rh_done),
    .bkt_o   (rh_bkt)
  );

  // compare the fetched entry against the job key
  assign is_rev = (job_q.command == nat_pkg::CmdRevLookup);
  always_comb begin
    if (is_rev) begin
      hit = (en_rdata.dst_ip == job_q.key.src_ip) && (en_rdata.gw_ip == job_q.key.dst_ip) &&
            (en_rdata.dport == job_q.key.sport) &&
            (en_rdata.gw_port == job_q.key.dport) &&
            (en_rdata.protocol == job_q.key.protocol);
      nxt = nr_rdata;
    end else begin
      hit = (en_rdata.src_ip == job_q.key.src_ip) && (en_rdata.dst_ip == job_q.key.dst_ip) &&
            (en_rdata.sport == job_q.key.sport) &&
            (en_rdata.dport == job_q.key.dport) &&
            (en_rdata.protocol == job_q.key.protocol);
      nxt = nf_rdata;
    end
  end

  assign take = job_valid_i && !out_valid_q && (state_q == SIdle);

  // sequencer
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    r_d         = r_q;
    fc_d        = fc_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    res_d       = res_q;
    rh_start    = 1'b0;
    fh_we = 1'b0; fh_waddr = '0; fh_wdata = '0; fh_raddr = '0;
    rh_we = 1'b0; rh_waddr = '0; rh_wdata = '0; rh_raddr = '0;
    en_we = 1'b0; en_waddr = '0; en_wdata = '0; en_raddr = '0;
    nf_we = 1'b0; nf_waddr = '0; nf_wdata = '0; nf_raddr = '0;
    nr_we = 1'b0; nr_waddr = '0; nr_wdata = '0; nr_raddr = '0;
    fs_we = 1'b0; fs_waddr = '0; fs_wdata = '0; fs_raddr = '0;

    // drop the result beat once taken
    if (out_pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SClear: begin
        fh_we    = 1'b1;
        fh_waddr = clr_q;
        fh_wdata = nat_pkg::PtrNull;
        rh_we    = 1'b1;
        rh_waddr = clr_q;
        rh_wdata = nat_pkg::PtrNull;
        if (clr_q < BktW'(nat_pkg::Entries)) begin
          fs_we    = 1'b1;
          fs_waddr = clr_q[IdxW-1:0];
          fs_wdata = IdxW'(nat_pkg::Entries - 1) - clr_q[IdxW-1:0];
        end
        if (clr_q == BktW'(nat_pkg::Buckets - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (take) begin
          prev_d = nat_pkg::PtrNull;
          if (job_i.command == nat_pkg::CmdInsert) begin
            if (fc_q == '0) begin
              out_valid_d = 1'b1;
              status_d    = nat_pkg::StFull;
              res_d       = '0;
            end else begin
              state_d = SInsRd;
            end
          end else begin
            state_d = SHead;
          end
        end
      end
      SInsRd: begin
        fs_raddr = IdxW'(fc_q - 1'b1);
        fh_raddr = job_q.key_bkt;
        rh_raddr = job_q.gw_bkt;
        state_d  = SInsWr;
      end
      SInsWr: begin
        en_we    = 1'b1;
        en_waddr = fs_rdata;
        en_wdata = job_q.key;
        nf_we    = 1'b1;
        nf_waddr = fs_rdata;
        nf_wdata = fh_rdata;
        nr_we    = 1'b1;
        nr_waddr = fs_rdata;
        nr_wdata = rh_rdata;
        fh_we    = 1'b1;
        fh_waddr = job_q.key_bkt;
        fh_wdata = {1'b0, fs_rdata};
        rh_we    = 1'b1;
        rh_waddr = job_q.gw_bkt;
        rh_wdata = {1'b0, fs_rdata};
        fc_d        = fc_q - 1'b1;
        out_valid_d = 1'b1;
        status_d    = nat_pkg::StOk;
        res_d       = job_q.key;
        state_d     = SIdle;
      end
      SHead: begin
        fh_raddr = job_q.key_bkt;
        rh_raddr = job_q.key_bkt;
        state_d  = SHeadW;
      end
      SHeadW: begin
        cur_d   = is_rev ? rh_rdata : fh_rdata;
        state_d = SChk;
      end
      SChk: begin
        if (cur_q[IdxW]) begin
          out_valid_d = 1'b1;
          status_d    = nat_pkg::StMiss;
          res_d       = '0;
          state_d     = SIdle;
        end else begin
          en_raddr = cur_q[IdxW-1:0];
          nf_raddr = cur_q[IdxW-1:0];
          nr_raddr = cur_q[IdxW-1:0];
          state_d  = SCmp;
        end
      end
      SCmp: begin
        if (!hit) begin
          prev_d  = cur_q;
          cur_d   = nxt;
          state_d = SChk;
        end else if (job_q.command != nat_pkg::CmdRemove) begin
          out_valid_d = 1'b1;
          status_d    = nat_pkg::StOk;
          res_d       = en_rdata;
          state_d     = SIdle;
        end else begin
          // unlink from the forward chain, then hash the reverse tuple
          if (prev_q[IdxW]) begin
            fh_we    = 1'b1;
            fh_waddr = job_q.key_bkt;
            fh_wdata = nf_rdata;
          end else begin
            nf_we    = 1'b1;
            nf_waddr = prev_q[IdxW-1:0];
            nf_wdata = nf_rdata;
          end
          rh_start = 1'b1;
          state_d  = SRHash;
        end
      end
      SRHash: begin
        prev_d = nat_pkg::PtrNull;
        if (rh_done) begin
          state_d = SRHead;
        end
      end
      SRHead: begin
        rh_raddr = rbkt_q;
        state_d  = SRHeadW;
      end
      SRHeadW: begin
        r_d     = rh_rdata;
        state_d = SRChk;
      end
      SRChk: begin
        if (r_q[IdxW]) begin
          state_d = SFree;
        end else begin
          nr_raddr = r_q[IdxW-1:0];
          state_d  = SRCmp;
        end
      end
      SRCmp: begin
        if (r_q == cur_q) begin
          if (prev_q[IdxW]) begin
            rh_we    = 1'b1;
            rh_waddr = rbkt_q;
            rh_wdata = nr_rdata;
          end else begin
            nr_we    = 1'b1;
            nr_waddr = prev_q[IdxW-1:0];
            nr_wdata = nr_rdata;
          end
          state_d = SFree;
        end else begin
          prev_d  = r_q;
          r_d     = nr_rdata;
          state_d = SRChk;
        end
      end
      SFree: begin
        if (fc_q < (IdxW+1)'(nat_pkg::Entries)) begin
          fs_we    = 1'b1;
          fs_waddr = fc_q[IdxW-1:0];
          fs_wdata = cur_q[IdxW-1:0];
          fc_d     = fc_q + 1'b1;
        end
        out_valid_d = 1'b1;
        status_d    = nat_pkg::StOk;
        res_d       = ent_q;
        state_d     = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      fc_q        <= (IdxW+1)'(nat_pkg::Entries);
      out_valid_q <= 1'b0;
      cur_q       <= nat_pkg::PtrNull;
      prev_q      <= nat_pkg::PtrNull;
      r_q         <= nat_pkg::PtrNull;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      r_q         <= r_d;
      if (state_q == SClear) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    res_q    <= res_d;
    if (take) begin
      job_q <= job_i;
    end
    if (rh_start) begin
      ent_q <= en_rdata;
    end
    if (rh_done) begin
      rbkt_q <= rh_bkt;
    end
  end

  assign job_pop_o   = take;
  assign init_o      = (state_q == SClear);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign res_o       = res_q;

endmodule

/* design/bidirectional_nat_hash_table.sv */
// NAT table with forward and reverse chained hash indexes.
// Each accepted command is hashed in the front end and passed through the job queue to
// the back end, where a lookup or remove walks its bucket chain and a remove then also
// walks the reverse chain. A new command is taken only once the previous job is queued;
// the back end runs one job at a time and waits while its result beat is unpopped.
// Reset: async, active low; a clearing pass of the bucket heads and the free stack then
// holds full high.
`timescale 1ns / 1ps
module bidirectional_nat_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic [31:0] key_src_ip_i,
  input  logic [31:0] key_dst_ip_i,
  input  logic [15:0] key_src_port_i,
  input  logic [15:0] key_dst_port_i,
  input  logic [7:0]  key_protocol_i,
  input  logic [31:0] gw_ip_i,
  input  logic [15:0] gw_port_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [31:0] res_src_ip_o,
  output logic [31:0] res_dst_ip_o,
  output logic [15:0] res_src_port_o,
  output logic [15:0] res_dst_port_o,
  output logic [7:0]  res_protocol_o,
  output logic [31:0] res_gateway_ip_o,
  output logic [15:0] res_gateway_port_o
);

  nat_pkg::entry_t item;
  nat_pkg::entry_t res;
  nat_pkg::job_t   job;
  logic            job_valid;
  logic            job_pop;
  logic            front_full;
  logic            init;
  logic            out_valid;
  logic            accept;

  assign item = '{src_ip: key_src_ip_i, dst_ip: key_dst_ip_i, sport: key_src_port_i,
                  dport: key_dst_port_i, protocol: key_protocol_i,
                  gw_ip: gw_ip_i, gw_port: gw_port_i};

  assign full   = front_full | init;
  assign accept = push && !full;

  nat_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (command_i),
    .item_i      (item),
    .full_o      (front_full),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_pop_i   (job_pop)
  );

  nat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .init_o      (init),
    .out_valid_o (out_valid),
    .out_pop_i   (pop),
    .status_o    (status_o),
    .res_o       (res)
  );

  // result beat fields
  assign empty              = !out_valid;
  assign res_src_ip_o       = res.src_ip;
  assign res_dst_ip_o       = res.dst_ip;
  assign res_src_port_o     = res.sport;
  assign res_dst_port_o     = res.dport;
  assign res_protocol_o     = res.protocol;
  assign res_gateway_ip_o   = res.gw_ip;
  assign res_gateway_port_o = res.gw_port;

`ifndef SYNTHESIS
  // no command is taken while the clearing pass runs
  assert property (@(posedge clk_i) disable iff (!rst_ni) init |-> full)
    else $error("input taken during clearing pass");

  // a miss or full result carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != nat_pkg::StOk) |-> (res_src_ip_o == '0 && res_gateway_ip_o == '0))
    else $error("non-ok result carries data");

  // only defined status codes appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == nat_pkg::StOk || status_o == nat_pkg::StMiss ||
                status_o == nat_pkg::StFull))
    else $error("undefined status code");
`endif

endmodule

/* bench/nat_table_checker.sv */
// Checker for the NAT translation table: watches the command and result queues,
// predicts each result from its own copy of the table, and counts mismatches.
// Depends on nat_pkg.
`timescale 1ns / 1ps
module nat_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [1:0]  command_i,
  input  logic [31:0] key_src_ip_i,
  input  logic [31:0] key_dst_ip_i,
  input  logic [15:0] key_src_port_i,
  input  logic [15:0] key_dst_port_i,
  input  logic [7:0]  key_protocol_i,
  input  logic [31:0] gw_ip_i,
  input  logic [15:0] gw_port_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] res_src_ip_i,
  input  logic [31:0] res_dst_ip_i,
  input  logic [15:0] res_src_port_i,
  input  logic [15:0] res_dst_port_i,
  input  logic [7:0]  res_protocol_i,
  input  logic [31:0] res_gateway_ip_i,
  input  logic [15:0] res_gateway_port_i,
  output int          errors_o,
  output int          pending_o,
  output int          beats_in_o,
  output int          beats_out_o,
  output int          hits_o,
  output int          fulls_o
);

  typedef struct packed {
    logic [1:0]      status;
    nat_pkg::entry_t ent;
  } verdict_t;

  // shadow table
  int unsigned     fwd_head [nat_pkg::Buckets];
  int unsigned     rev_head [nat_pkg::Buckets];
  nat_pkg::entry_t slot     [nat_pkg::Entries];
  int unsigned     fwd_next [nat_pkg::Entries];
  int unsigned     rev_next [nat_pkg::Entries];
  int unsigned     free_idx [nat_pkg::Entries];
  int unsigned     free_cnt;

  verdict_t expected_q[$];

  function automatic int unsigned fnv_bucket(logic [31:0] a, logic [31:0] b,
                                             logic [31:0] c, logic [31:0] d,
                                             logic [31:0] e);
    logic [31:0] h;
    h = nat_pkg::FnvBasis;
    h = (h ^ a) * nat_pkg::FnvPrime;
    h = (h ^ b) * nat_pkg::FnvPrime;
    h = (h ^ c) * nat_pkg::FnvPrime;
    h = (h ^ d) * nat_pkg::FnvPrime;
    h = (h ^ e) * nat_pkg::FnvPrime;
    return h % nat_pkg::Buckets;
  endfunction

  function automatic int unsigned rev_bucket(nat_pkg::entry_t k);
    return fnv_bucket(k.dst_ip, k.gw_ip, 32'(k.dport), 32'(k.gw_port), 32'(k.protocol));
  endfunction

  function automatic bit same_flow(nat_pkg::entry_t x, nat_pkg::entry_t k);
    return x.src_ip == k.src_ip && x.dst_ip == k.dst_ip && x.sport == k.sport &&
           x.dport == k.dport && x.protocol == k.protocol;
  endfunction

  // reverse key arrives in the forward field order
  function automatic bit same_reply(nat_pkg::entry_t x, nat_pkg::entry_t k);
    return x.dst_ip == k.src_ip && x.gw_ip == k.dst_ip && x.dport == k.sport &&
           x.gw_port == k.dport && x.protocol == k.protocol;
  endfunction

  function automatic verdict_t translate(logic [1:0] cmd, nat_pkg::entry_t k);
    verdict_t v;
    int unsigned b, cur, prv, idx, n, r, rp, rb;
    v = '0;
    v.status = nat_pkg::StMiss;
    b = fnv_bucket(k.src_ip, k.dst_ip, 32'(k.sport), 32'(k.dport), 32'(k.protocol));
    case (cmd)
      nat_pkg::CmdInsert: begin
        if (free_cnt == 0) begin
          v.status = nat_pkg::StFull;
        end else begin
          free_cnt--;
          idx = free_idx[free_cnt];
          slot[idx] = k;
          fwd_next[idx] = fwd_head[b];
          fwd_head[b] = idx;
          rb = rev_bucket(k);
          rev_next[idx] = rev_head[rb];
          rev_head[rb] = idx;
          v.status = nat_pkg::StOk;
          v.ent = k;
        end
      end
      nat_pkg::CmdRevLookup: begin
        cur = rev_head[b];
        for (n = 0; cur < nat_pkg::Entries && n < nat_pkg::Entries; n++) begin
          if (same_reply(slot[cur], k)) begin
            v.status = nat_pkg::StOk;
            v.ent = slot[cur];
            break;
          end
          cur = rev_next[cur];
        end
      end
      default: begin
        prv = nat_pkg::Entries;
        cur = fwd_head[b];
        for (n = 0; cur < nat_pkg::Entries && n < nat_pkg::Entries; n++) begin
          if (same_flow(slot[cur], k)) break;
          prv = cur;
          cur = fwd_next[cur];
        end
        if (cur < nat_pkg::Entries && n < nat_pkg::Entries) begin
          v.status = nat_pkg::StOk;
          v.ent = slot[cur];
          if (cmd == nat_pkg::CmdRemove) begin
            if (prv == nat_pkg::Entries) fwd_head[b] = fwd_next[cur];
            else fwd_next[prv] = fwd_next[cur];
            rb = rev_bucket(slot[cur]);
            r = rev_head[rb];
            rp = nat_pkg::Entries;
            for (n = 0; r < nat_pkg::Entries && n < nat_pkg::Entries; n++) begin
              if (r == cur) begin
                if (rp == nat_pkg::Entries) rev_head[rb] = rev_next[r];
                else rev_next[rp] = rev_next[r];
                break;
              end
              rp = r;
              r = rev_next[r];
            end
            fwd_next[cur] = nat_pkg::Entries;
            rev_next[cur] = nat_pkg::Entries;
            if (free_cnt < nat_pkg::Entries) begin
              free_idx[free_cnt] = cur;
              free_cnt++;
            end
          end
        end
      end
    endcase
    if (v.status != nat_pkg::StOk) v.ent = '0;
    return v;
  endfunction

  initial begin
    for (int i = 0; i < nat_pkg::Buckets; i++) begin
      fwd_head[i] = nat_pkg::Entries;
      rev_head[i] = nat_pkg::Entries;
    end
    for (int i = 0; i < nat_pkg::Entries; i++) begin
      free_idx[i] = nat_pkg::Entries - 1 - i;
      fwd_next[i] = nat_pkg::Entries;
      rev_next[i] = nat_pkg::Entries;
      slot[i] = '0;
    end
    free_cnt = nat_pkg::Entries;
    errors_o = 0;
    pending_o = 0;
    beats_in_o = 0;
    beats_out_o = 0;
    hits_o = 0;
    fulls_o = 0;
  end

  // predict on each accepted command beat, compare on each accepted result beat
  always @(posedge clk_i) begin
    nat_pkg::entry_t k;
    verdict_t        got, want;
    if (rst_ni) begin
      if (push_i && !full_i) begin
        k = '{key_src_ip_i, key_dst_ip_i, key_src_port_i, key_dst_port_i, key_protocol_i,
              gw_ip_i, gw_port_i};
        want = translate(command_i, k);
        if (command_i != nat_pkg::CmdInsert && want.status == nat_pkg::StOk) hits_o++;
        if (want.status == nat_pkg::StFull) fulls_o++;
        expected_q.push_back(want);
        beats_in_o++;
      end
      if (pop_i && !empty_i) begin
        got.status = status_i;
        got.ent = '{res_src_ip_i, res_dst_ip_i, res_src_port_i, res_dst_port_i,
                    res_protocol_i, res_gateway_ip_i, res_gateway_port_i};
        beats_out_o++;
        if (expected_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result beat: %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 10)
              $display("result %0d mismatch: expected st=%0d %h, got st=%0d %h",
                       beats_out_o, want.status, want.ent, got.status, got.ent);
          end
        end
      end
      pending_o = expected_q.size();
    end
  end
endmodule

/* bench/tb.sv */
// Top of the NAT table bench: clock, reset, command stimulus and verdict.
// Depends on nat_pkg, nat_table_checker and the bidirectional_nat_hash_table RTL.
`timescale 1ns / 1ps
module tb;

  localparam int EntW = $bits(nat_pkg::entry_t);

  logic        clk_i, rst_ni, push, full, empty, pop;
  logic [1:0]  command_i;
  logic [31:0] key_src_ip_i, key_dst_ip_i, gw_ip_i;
  logic [15:0] key_src_port_i, key_dst_port_i, gw_port_i;
  logic [7:0]  key_protocol_i;
  logic [1:0]  status_o;
  logic [31:0] res_src_ip_o, res_dst_ip_o, res_gateway_ip_o;
  logic [15:0] res_src_port_o, res_dst_port_o, res_gateway_port_o;
  logic [7:0]  res_protocol_o;
  int errors, pending, beats_in, beats_out, hits, fulls;
  int idle_cycles;

  bidirectional_nat_hash_table dut (.*);

  nat_table_checker checker_i (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .command_i, .key_src_ip_i,
    .key_dst_ip_i, .key_src_port_i, .key_dst_port_i, .key_protocol_i, .gw_ip_i,
    .gw_port_i, .empty_i(empty), .pop_i(pop), .status_i(status_o),
    .res_src_ip_i(res_src_ip_o), .res_dst_ip_i(res_dst_ip_o),
    .res_src_port_i(res_src_port_o), .res_dst_port_i(res_dst_port_o),
    .res_protocol_i(res_protocol_o), .res_gateway_ip_i(res_gateway_ip_o),
    .res_gateway_port_i(res_gateway_port_o), .errors_o(errors), .pending_o(pending),
    .beats_in_o(beats_in), .beats_out_o(beats_out), .hits_o(hits), .fulls_o(fulls));

  // live flows, so lookups and removes mostly hit
  nat_pkg::entry_t flows[$];

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic nat_pkg::entry_t rand_flow();
    nat_pkg::entry_t e;
    e = EntW'({$urandom, $urandom, $urandom, $urandom, $urandom});
    // narrow some fields so buckets collide and keys repeat
    if ($urandom_range(0, 3) == 0) e.protocol = 8'd6;
    if ($urandom_range(0, 3) == 0) e.dst_ip = 32'h0A00_0001;
    return e;
  endfunction

  // hold push high across back-to-back beats, drop it only for a gap
  task automatic send(logic [1:0] cmd, nat_pkg::entry_t e);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    push <= 1'b1;
    command_i <= cmd;
    {key_src_ip_i, key_dst_ip_i, key_src_port_i, key_dst_port_i, key_protocol_i,
     gw_ip_i, gw_port_i} <= e;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // reverse key in forward field order
  function automatic nat_pkg::entry_t reply_key(nat_pkg::entry_t e);
    nat_pkg::entry_t r;
    r = EntW'({$urandom, $urandom, $urandom, $urandom, $urandom});
    r.src_ip = e.dst_ip;
    r.dst_ip = e.gw_ip;
    r.sport = e.dport;
    r.dport = e.gw_port;
    r.protocol = e.protocol;
    return r;
  endfunction

  task automatic random_cmd();
    nat_pkg::entry_t e;
    int unsigned r, i;
    r = $urandom_range(0, 99);
    if (flows.size() == 0 || r < 30) begin
      e = rand_flow();
      // sometimes a duplicate key with a new gateway
      if (flows.size() > 0 && $urandom_range(0, 7) == 0) begin
        e = flows[$urandom_range(0, flows.size() - 1)];
        e.gw_ip = $urandom;
      end
      send(nat_pkg::CmdInsert, e);
      flows.push_back(e);
    end else begin
      i = $urandom_range(0, flows.size() - 1);
      e = flows[i];
      if (r < 55) send(nat_pkg::CmdFwdLookup, e);
      else if (r < 75) send(nat_pkg::CmdRevLookup, reply_key(e));
      else if (r < 92) begin
        send(nat_pkg::CmdRemove, e);
        flows.delete(i);
      end else send(2'($urandom_range(1, 3)), rand_flow());
    end
  endtask

  // result side: random pop stalls
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(10, 60)) @(negedge clk_i);
      end else begin
        pop <= ($urandom_range(0, 99) < 70) ? 1'b1 : 1'b0;
      end
    end
  end

  // watchdog: no beat for too long ends the run
  initial begin
    int last_in, last_out;
    idle_cycles = 0;
    last_in = 0;
    last_out = 0;
    forever begin
      @(posedge clk_i);
      if (beats_in != last_in || beats_out != last_out) idle_cycles = 0;
      else idle_cycles++;
      last_in = beats_in;
      last_out = beats_out;
      if (idle_cycles > 5000) begin
        $display("timeout: no beat for 5000 cycles, %0d results outstanding", pending);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    nat_pkg::entry_t e, z, o;
    push = 1'b0;
    command_i = nat_pkg::CmdInsert;
    {key_src_ip_i, key_dst_ip_i, key_src_port_i, key_dst_port_i, key_protocol_i,
     gw_ip_i, gw_port_i} = '0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, misses, duplicates, removes
    z = '0;
    o = '1;
    send(nat_pkg::CmdFwdLookup, z);
    send(nat_pkg::CmdRevLookup, o);
    send(nat_pkg::CmdRemove, z);
    send(nat_pkg::CmdInsert, z);
    send(nat_pkg::CmdInsert, o);
    send(nat_pkg::CmdFwdLookup, z);
    send(nat_pkg::CmdFwdLookup, o);
    send(nat_pkg::CmdRevLookup, reply_key(o));
    send(nat_pkg::CmdRevLookup, reply_key(z));
    e = o;
    e.gw_port = 16'h1234;
    send(nat_pkg::CmdInsert, e);
    send(nat_pkg::CmdFwdLookup, o);
    send(nat_pkg::CmdRemove, o);
    send(nat_pkg::CmdFwdLookup, o);
    send(nat_pkg::CmdRemove, o);
    send(nat_pkg::CmdRemove, o);
    send(nat_pkg::CmdRemove, z);
    send(nat_pkg::CmdRevLookup, reply_key(z));

    // fill the pool past capacity, then drain it
    for (int i = 0; i < nat_pkg::Entries + 4; i++) begin
      e = rand_flow();
      send(nat_pkg::CmdInsert, e);
      if (i < nat_pkg::Entries) flows.push_back(e);
    end
    while (flows.size() > 0) begin
      send(nat_pkg::CmdRemove, flows[0]);
      void'(flows.pop_front());
    end

    for (int i = 0; i < 670; i++) random_cmd();
    push <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d commands, %0d lookup/remove hits, %0d inserts into a full pool",
             beats_in, hits, fulls);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* sim.f */
design/nat_pkg.sv
design/nat_ram.sv
design/nat_hash.sv
design/nat_front.sv
design/nat_back.sv
design/bidirectional_nat_hash_table.sv
bench/nat_table_checker.sv
bench/tb.sv
